FILE: sv/nbp_pkg.sv
// ----------------------------------------------------------------------------
// nbp_pkg
// Shared types, register codes and fixed-point helpers of the n-body step.
// ----------------------------------------------------------------------------
package nbp_pkg;

   typedef struct packed {
      logic               kind;
      logic [9:0]         body_index;
      logic signed [31:0] in_pos_x;
      logic signed [31:0] in_pos_y;
      logic signed [31:0] in_pos_z;
      logic [31:0]        in_mass;
      logic signed [31:0] in_vel_x;
      logic signed [31:0] in_vel_y;
      logic signed [31:0] in_vel_z;
      logic [31:0]        in_inv_mass;
   } nbp_req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic [31:0]        out_mass;
      logic signed [31:0] out_vel_x;
      logic signed [31:0] out_vel_y;
      logic signed [31:0] out_vel_z;
      logic [31:0]        out_inv_mass;
   } nbp_rsp_type;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   localparam logic [1:0] CSR_TIME_STEP  = 2'd0;
   localparam logic [1:0] CSR_DAMPING    = 2'd1;
   localparam logic [1:0] CSR_SOFTENING  = 2'd2;
   localparam logic [1:0] CSR_BODY_COUNT = 2'd3;

   localparam logic [31:0] TIME_STEP_RST  = 32'd655;
   localparam logic [16:0] DAMPING_RST    = 17'h10000;
   localparam logic [31:0] SOFTENING_RST  = 32'd66;
   localparam logic [10:0] BODY_COUNT_RST = 11'd0;

   localparam int DIST_W = 50;
   localparam logic [31:0] INV_MAX = 32'hFFFF_FFFF;

   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
   localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
   localparam logic signed [64:0] S32_MIN = -65'sd2147483648;

   // floor(p / 2^sh), capped at 2^63-1
   function automatic logic [63:0] cap_shr(input logic [127:0] p, input int unsigned sh);
      logic [127:0] q;
      q = p >> sh;
      if (|q[127:63]) return S64_MAX;
      return q[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   function automatic logic [63:0] satadd64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [64:0] x);
      if (x > S32_MAX) return 32'h7FFF_FFFF;
      if (x < S32_MIN) return 32'h8000_0000;
      return x[31:0];
   endfunction

endpackage

FILE: sv/nbp_front.sv
// ----------------------------------------------------------------------------
// nbp_front
// Request intake: two-entry queue that decouples the port from the engine.
// ----------------------------------------------------------------------------
module nbp_front
   import nbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  nbp_req_type req_data,
   output logic        q_valid,
   output nbp_req_type q_item,
   input  logic        q_pop
);

   nbp_req_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("request queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> cnt_ff != 2'd0)
      else $error("pop from empty request queue");

endmodule

FILE: sv/nbp_mul.sv
// ----------------------------------------------------------------------------
// nbp_mul
// 64 x 64 unsigned multiplier, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module nbp_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] prod
);

   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [127:0] pp_sh;

   assign done = done_ff;
   assign prod = acc_ff;

   always_comb begin
      a_half = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (sh_ff)
         2'd0:    pp_sh = {64'd0, pp_ff};
         2'd1:    pp_sh = {32'd0, pp_ff, 32'd0};
         default: pp_sh = {pp_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (go) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff != 3'd4) begin
            pp_ff <= a_half * b_half;
            sh_ff <= 2'(step_ff[1]) + 2'(step_ff[0]);
         end
         if (step_ff != 3'd0) acc_ff <= acc_ff + pp_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   a_go_idle: assert property (@(posedge clock) disable iff (reset) go |-> !busy_ff)
      else $error("multiplier started while busy");

endmodule

FILE: sv/nbp_rsqrt.sv
// ----------------------------------------------------------------------------
// nbp_rsqrt
// Inverse distance floor(2^32 / sqrt(d)): restoring divide, then digit sqrt.
// ----------------------------------------------------------------------------
module nbp_rsqrt
   import nbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [DIST_W-1:0] d,
   output logic              done,
   output logic [31:0]       inv
);

   typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rs_state_type;

   rs_state_type      st_ff;
   logic [DIST_W-1:0] d_ff;
   logic [DIST_W-1:0] rem_ff;
   logic [63:0]       quo_ff;
   logic [6:0]        cnt_ff;
   logic [33:0]       srem_ff;
   logic [31:0]       root_ff;
   logic              done_ff;
   logic [31:0]       inv_ff;
   logic [DIST_W:0]   rem_sh;
   logic              qbit;
   logic [DIST_W:0]   rem_in;
   logic [35:0]       srem_sh;
   logic [35:0]       trial;
   logic              sbit;
   logic [35:0]       srem_in;

   assign done = done_ff;
   assign inv  = inv_ff;

   always_comb begin
      rem_sh  = {rem_ff, (cnt_ff == 7'd64)};
      qbit    = (rem_sh >= {1'b0, d_ff});
      rem_in  = qbit ? rem_sh - {1'b0, d_ff} : rem_sh;
      srem_sh = {srem_ff, quo_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      sbit    = (srem_sh >= trial);
      srem_in = sbit ? srem_sh - trial : srem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= R_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            R_IDLE: begin
               if (go) begin
                  if (d == '0) begin
                     inv_ff  <= '0;
                     done_ff <= 1'b1;
                  end else if (d == DIST_W'(1)) begin
                     inv_ff  <= INV_MAX;
                     done_ff <= 1'b1;
                  end else begin
                     d_ff   <= d;
                     rem_ff <= '0;
                     quo_ff <= '0;
                     cnt_ff <= 7'd64;
                     st_ff  <= R_DIV;
                  end
               end
            end
            R_DIV: begin
               rem_ff <= rem_in[DIST_W-1:0];
               quo_ff <= {quo_ff[62:0], qbit};
               cnt_ff <= cnt_ff - 7'd1;
               if (cnt_ff == 7'd0) begin
                  srem_ff <= '0;
                  root_ff <= '0;
                  cnt_ff  <= 7'd31;
                  st_ff   <= R_SQRT;
               end
            end
            R_SQRT: begin
               srem_ff <= srem_in[33:0];
               root_ff <= {root_ff[30:0], sbit};
               quo_ff  <= {quo_ff[61:0], 2'b00};
               cnt_ff  <= cnt_ff - 7'd1;
               if (cnt_ff == 7'd0) begin
                  inv_ff  <= {root_ff[30:0], sbit};
                  done_ff <= 1'b1;
                  st_ff   <= R_IDLE;
               end
            end
            default: st_ff <= R_IDLE;
         endcase
      end
   end

   a_go_idle: assert property (@(posedge clock) disable iff (reset) go |-> st_ff == R_IDLE)
      else $error("inverse distance started while busy");

endmodule

FILE: sv/nbp_engine.sv
// ----------------------------------------------------------------------------
// nbp_engine
// Body store, register file and the sequencer for force sum and update.
// ----------------------------------------------------------------------------
module nbp_engine
   import nbp_pkg::*;
#(
   parameter int MAX_BODIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  nbp_req_type q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output nbp_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int CLW = $clog2(MAX_BODIES + 1);
   localparam int XW  = (CLW > 11) ? CLW : 11;
   localparam int AW  = $clog2(MAX_BODIES);
   localparam logic [XW-1:0] MAX_X = XW'(MAX_BODIES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_REDUCE, ST_RD_I, ST_CHK, ST_LD_J, ST_SQ, ST_RSQ, ST_SQR2,
      ST_CUBE, ST_SCL, ST_TERM, ST_U_ACC, ST_U_DV, ST_U_DMP, ST_U_POS, ST_OUT
   } eng_state_type;

   eng_state_type     st_ff;
   logic [31:0]       time_step_ff;
   logic [16:0]       damping_ff;
   logic [31:0]       softening_ff;
   logic [10:0]       body_count_ff;

   logic [3:0][31:0]  pos_mem [MAX_BODIES];
   logic [3:0][31:0]  vel_mem [MAX_BODIES];
   logic [3:0][31:0]  pos_q;
   logic [3:0][31:0]  vel_q;
   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     rd_addr;

   nbp_req_type       item_ff;
   logic [XW-1:0]     idx_ff;
   logic [XW-1:0]     j_ff;
   logic [XW-1:0]     n_ff;
   logic [XW-1:0]     cnt_ext;
   logic [3:0][31:0]  pi_ff;
   logic [3:0][31:0]  vi_ff;
   logic [32:0]       r_ff [3];
   logic [32:0]       r_in [3];
   logic [31:0]       mj_ff;
   logic [DIST_W-1:0] d_ff;
   logic [DIST_W-1:0] d_next;
   logic [31:0]       inv_ff;
   logic [55:0]       s_ff;
   logic [63:0]       f_ff [3];
   logic [1:0]        ax_ff;
   logic [1:0]        ax_nx;
   logic [31:0]       opos_ff [3];
   logic [31:0]       ovel_ff [3];
   logic              rsp_valid_ff;
   nbp_rsp_type       rsp_data_ff;

   logic              mul_go_ff;
   logic [63:0]       mul_a_ff;
   logic [63:0]       mul_b_ff;
   logic              neg_ff;
   logic              mul_done;
   logic [127:0]      mul_prod;
   logic              rsq_go_ff;
   logic              rsq_done;
   logic [31:0]       rsq_inv;

   logic [63:0]       scaled;
   logic [63:0]       res;
   logic [63:0]       v_sum;
   logic [31:0]       v32;
   logic [63:0]       v32_x;
   logic [31:0]       p32;

   function automatic logic [63:0] mag_r(input logic [32:0] r);
      logic [32:0] m;
      m = r[32] ? -r : r;
      return 64'(m);
   endfunction

   nbp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go_ff),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   nbp_rsqrt u_rsqrt (
      .clock (clock),
      .reset (reset),
      .go    (rsq_go_ff),
      .d     (d_ff),
      .done  (rsq_done),
      .inv   (rsq_inv)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign q_pop     = (st_ff == ST_IDLE) && q_valid;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r_in[k] = {pos_q[k][31], pos_q[k]} - {pi_ff[k][31], pi_ff[k]};
      end
      mem_we  = (st_ff == ST_REDUCE) && (idx_ff < MAX_X) && (item_ff.kind == KIND_LOAD);
      mem_re  = ((st_ff == ST_REDUCE) && (idx_ff < MAX_X) && (item_ff.kind == KIND_COMPUTE))
             || ((st_ff == ST_CHK) && (j_ff < n_ff));
      rd_addr = (st_ff == ST_CHK) ? AW'(j_ff) : AW'(idx_ff);
      cnt_ext = XW'(body_count_ff);
      d_next  = d_ff + DIST_W'(mul_prod[64:16]);
      ax_nx   = ax_ff + 2'd1;
      scaled  = cap_shr(mul_prod, 16);
      res     = neg_ff ? -scaled : scaled;
      v_sum   = satadd64({{32{vi_ff[ax_ff][31]}}, vi_ff[ax_ff]}, res);
      v32     = sat32({res[63], res});
      v32_x   = {{32{v32[31]}}, v32};
      p32     = sat32({{33{pi_ff[ax_ff][31]}}, pi_ff[ax_ff]} + {res[63], res});
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[AW'(idx_ff)] <= {item_ff.in_mass, item_ff.in_pos_z,
                                  item_ff.in_pos_y, item_ff.in_pos_x};
         vel_mem[AW'(idx_ff)] <= {item_ff.in_inv_mass, item_ff.in_vel_z,
                                  item_ff.in_vel_y, item_ff.in_vel_x};
      end
      if (mem_re) begin
         pos_q <= pos_mem[rd_addr];
         vel_q <= vel_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         mul_go_ff     <= 1'b0;
         rsq_go_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         time_step_ff  <= TIME_STEP_RST;
         damping_ff    <= DAMPING_RST;
         softening_ff  <= SOFTENING_RST;
         body_count_ff <= BODY_COUNT_RST;
      end else begin
         mul_go_ff <= 1'b0;
         rsq_go_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TIME_STEP:  time_step_ff  <= csr_data;
               CSR_DAMPING:    damping_ff    <= csr_data[16:0];
               CSR_SOFTENING:  softening_ff  <= csr_data;
               CSR_BODY_COUNT: body_count_ff <= csr_data[10:0];
               default:        time_step_ff  <= time_step_ff;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff <= q_item;
                  idx_ff  <= XW'(q_item.body_index);
                  st_ff   <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               if (idx_ff >= MAX_X) idx_ff <= idx_ff - MAX_X;
               else if (item_ff.kind == KIND_LOAD) st_ff <= ST_IDLE;
               else st_ff <= ST_RD_I;
            end
            ST_RD_I: begin
               pi_ff <= pos_q;
               vi_ff <= vel_q;
               for (int k = 0; k < 3; k++) f_ff[k] <= '0;
               j_ff  <= '0;
               n_ff  <= (cnt_ext > MAX_X) ? MAX_X : cnt_ext;
               st_ff <= ST_CHK;
            end
            ST_CHK: begin
               if (j_ff < n_ff) begin
                  st_ff <= ST_LD_J;
               end else begin
                  ax_ff     <= 2'd0;
                  mul_a_ff  <= mag64(f_ff[0]);
                  mul_b_ff  <= {32'd0, vi_ff[3]};
                  neg_ff    <= f_ff[0][63];
                  mul_go_ff <= 1'b1;
                  st_ff     <= ST_U_ACC;
               end
            end
            ST_LD_J: begin
               for (int k = 0; k < 3; k++) r_ff[k] <= r_in[k];
               mj_ff     <= pos_q[3];
               d_ff      <= DIST_W'(softening_ff);
               ax_ff     <= 2'd0;
               mul_a_ff  <= mag_r(r_in[0]);
               mul_b_ff  <= mag_r(r_in[0]);
               mul_go_ff <= 1'b1;
               st_ff     <= ST_SQ;
            end
            ST_SQ: begin
               if (mul_done) begin
                  d_ff <= d_next;
                  if (ax_ff == 2'd2) begin
                     rsq_go_ff <= 1'b1;
                     st_ff     <= ST_RSQ;
                  end else begin
                     ax_ff     <= ax_nx;
                     mul_a_ff  <= mag_r(r_ff[ax_nx]);
                     mul_b_ff  <= mag_r(r_ff[ax_nx]);
                     mul_go_ff <= 1'b1;
                  end
               end
            end
            ST_RSQ: begin
               if (rsq_done) begin
                  if (rsq_inv == '0) begin
                     j_ff  <= j_ff + XW'(1);
                     st_ff <= ST_CHK;
                  end else begin
                     inv_ff    <= rsq_inv;
                     mul_a_ff  <= {32'd0, rsq_inv};
                     mul_b_ff  <= {32'd0, rsq_inv};
                     mul_go_ff <= 1'b1;
                     st_ff     <= ST_SQR2;
                  end
               end
            end
            ST_SQR2: begin
               if (mul_done) begin
                  mul_a_ff  <= mul_prod[63:0];
                  mul_b_ff  <= {32'd0, inv_ff};
                  mul_go_ff <= 1'b1;
                  st_ff     <= ST_CUBE;
               end
            end
            ST_CUBE: begin
               if (mul_done) begin
                  mul_a_ff  <= {32'd0, mj_ff};
                  mul_b_ff  <= {16'd0, mul_prod[95:48]};
                  mul_go_ff <= 1'b1;
                  st_ff     <= ST_SCL;
               end
            end
            ST_SCL: begin
               if (mul_done) begin
                  s_ff      <= mul_prod[79:24];
                  ax_ff     <= 2'd0;
                  mul_a_ff  <= mag_r(r_ff[0]);
                  mul_b_ff  <= {8'd0, mul_prod[79:24]};
                  neg_ff    <= r_ff[0][32];
                  mul_go_ff <= 1'b1;
                  st_ff     <= ST_TERM;
               end
            end
            ST_TERM: begin
               if (mul_done) begin
                  f_ff[ax_ff] <= satadd64(f_ff[ax_ff], res);
                  if (ax_ff == 2'd2) begin
                     j_ff  <= j_ff + XW'(1);
                     st_ff <= ST_CHK;
                  end else begin
                     ax_ff     <= ax_nx;
                     mul_a_ff  <= mag_r(r_ff[ax_nx]);
                     mul_b_ff  <= {8'd0, s_ff};
                     neg_ff    <= r_ff[ax_nx][32];
                     mul_go_ff <= 1'b1;
                  end
               end
            end
            ST_U_ACC: begin
               if (mul_done) begin
                  mul_a_ff  <= mag64(res);
                  mul_b_ff  <= {32'd0, time_step_ff};
                  neg_ff    <= res[63];
                  mul_go_ff <= 1'b1;
                  st_ff     <= ST_U_DV;
               end
            end
            ST_U_DV: begin
               if (mul_done) begin
                  mul_a_ff  <= mag64(v_sum);
                  mul_b_ff  <= {47'd0, damping_ff};
                  neg_ff    <= v_sum[63];
                  mul_go_ff <= 1'b1;
                  st_ff     <= ST_U_DMP;
               end
            end
            ST_U_DMP: begin
               if (mul_done) begin
                  ovel_ff[ax_ff] <= v32;
                  mul_a_ff  <= mag64(v32_x);
                  mul_b_ff  <= {32'd0, time_step_ff};
                  neg_ff    <= v32[31];
                  mul_go_ff <= 1'b1;
                  st_ff     <= ST_U_POS;
               end
            end
            ST_U_POS: begin
               if (mul_done) begin
                  opos_ff[ax_ff] <= p32;
                  if (ax_ff == 2'd2) begin
                     st_ff <= ST_OUT;
                  end else begin
                     ax_ff     <= ax_nx;
                     mul_a_ff  <= mag64(f_ff[ax_nx]);
                     mul_b_ff  <= {32'd0, vi_ff[3]};
                     neg_ff    <= f_ff[ax_nx][63];
                     mul_go_ff <= 1'b1;
                     st_ff     <= ST_U_ACC;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_data_ff.out_pos_x    <= opos_ff[0];
                  rsp_data_ff.out_pos_y    <= opos_ff[1];
                  rsp_data_ff.out_pos_z    <= opos_ff[2];
                  rsp_data_ff.out_mass     <= pi_ff[3];
                  rsp_data_ff.out_vel_x    <= ovel_ff[0];
                  rsp_data_ff.out_vel_y    <= ovel_ff[1];
                  rsp_data_ff.out_vel_z    <= ovel_ff[2];
                  rsp_data_ff.out_inv_mass <= vi_ff[3];
                  rsp_valid_ff             <= 1'b1;
                  st_ff                    <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("response changed while stalled");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop without a queued request");
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_we |-> st_ff == ST_IDLE && !q_valid)
      else $error("register write while a request is in flight");

endmodule

FILE: sv/nbody_all_pairs_step.sv
// ----------------------------------------------------------------------------
// nbody_all_pairs_step
// All-pairs softened gravity step over a body store, signed Q16.16.
//
// A request with kind load writes one body (position, mass, velocity,
// inverse mass) into the store at body_index modulo MAX_BODIES and gives no
// response. A request with kind compute sums the pull of bodies 0 up to
// min(body_count, MAX_BODIES)-1 on the named body and returns one response
// with its updated position and velocity; the store is not written back.
// Requests enter through a two-entry queue, so a new request is taken while
// the engine works. Items are handled one at a time; a compute is done by
// one shared 64-bit multiplier, used for every product, and a bit-serial
// inverse square root for each pair. Index wrap subtracts MAX_BODIES
// repeatedly in ST_REDUCE until the index is in range.
// The response sits in an output register; while rsp_stall is high it holds
// and the engine waits before its next response. Reset clears the control
// state and sets the registers to their reset values; store contents stay
// undefined until loaded. Registers are to be written by the user only while
// the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module nbody_all_pairs_step
   import nbp_pkg::*;
#(
   parameter int MAX_BODIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  nbp_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output nbp_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic        q_valid;
   nbp_req_type q_item;
   logic        q_pop;

   nbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   nbp_engine #(
      .MAX_BODIES (MAX_BODIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
